// ===== design/qat_pkg.sv =====
// Package for the quoted argument tokenizer: size limits, character codes,
// quote and status encodings, and the result field layout.
// No dependencies; every design and checker file refers to it by scoped names.
`default_nettype none

package qat_pkg;

  localparam int MAX_ARGS = 256;
  localparam int MAX_LEN  = 4096;

  // Counter widths follow from the limits; the counters must hold the limit itself.
  localparam int CNT_W = $clog2(MAX_ARGS + 1);
  localparam int POS_W = $clog2(MAX_LEN + 1);

  // Fixed widths of the result fields.
  localparam int CHAR_W   = 8;
  localparam int IDX_W    = 8;
  localparam int SPOS_W   = 13;
  localparam int STATUS_W = 2;
  localparam int ACNT_W   = 9;

  // Result tdata layout, lowest bit first.
  localparam int APPEND_LSB    = 0;
  localparam int OUT_CHAR_LSB  = APPEND_LSB + 1;
  localparam int NEW_ARG_LSB   = OUT_CHAR_LSB + CHAR_W;
  localparam int ARG_NUM_LSB   = NEW_ARG_LSB + 1;
  localparam int START_POS_LSB = ARG_NUM_LSB + IDX_W;
  localparam int END_POS_LSB   = START_POS_LSB + SPOS_W;
  localparam int ARG_ENDED_LSB = END_POS_LSB + SPOS_W;
  localparam int STATUS_LSB    = ARG_ENDED_LSB + 1;
  localparam int ARG_COUNT_LSB = STATUS_LSB + STATUS_W;
  localparam int RES_BITS      = ARG_COUNT_LSB + ACNT_W;
  localparam int RES_W         = ((RES_BITS + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE    = 8'h27;
  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;

  typedef enum logic [1:0] {
    Q_NONE,
    Q_DOUBLE,
    Q_SINGLE
  } quote_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_UNTERMINATED,
    STAT_OVERFLOW
  } status_t;

endpackage

`default_nettype wire

// ===== design/quoted_argument_tokenizer.sv =====
// Shell-style argument tokenizer: one byte per transaction, one result per byte.
// The result of an accepted byte is in the output register from the next cycle.
// Throughput is one byte per cycle; the output register is refilled in the cycle
// it drains, so only a stalled consumer holds back the input.
// Synchronous active-high reset clears the parse state and empties the output register.
// Depends on qat_pkg.
`default_nettype none

module quoted_argument_tokenizer (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  input  wire  [7:0]              s_tdata,   // ch[7:0]
  input  wire                     s_tlast,   // end_of_string
  output logic                    m_tvalid,
  input  wire                     m_tready,
  output logic [qat_pkg::RES_W-1:0] m_tdata, // append, out_char, new_arg, arg_num,
                                             // start_pos, end_pos, arg_ended, status,
                                             // arg_count
  output logic                    m_tlast    // done_res
);

  // Parse state
  qat_pkg::quote_t               open_quote, open_quote_next;
  logic                          inside_arg, inside_arg_next;
  logic                          escape_pending, escape_pending_next;
  logic [qat_pkg::CNT_W-1:0]     count_of_args, count_of_args_next;
  logic [qat_pkg::POS_W-1:0]     char_position, char_position_next;
  logic [qat_pkg::POS_W-1:0]     last_end, last_end_next;
  logic                          overflowed, overflowed_next;

  // Per-byte decode
  logic                          accept;
  logic                          is_dq, is_sq, is_quote, is_bs, is_blank, quote_match;
  logic                          take, app, newa, ended;
  logic [qat_pkg::POS_W-1:0]     start;
  qat_pkg::status_t              status;
  logic [qat_pkg::RES_W-1:0]     res_data;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;

  assign is_dq    = s_tdata == qat_pkg::CH_DQUOTE;
  assign is_sq    = s_tdata == qat_pkg::CH_SQUOTE;
  assign is_quote = is_dq || is_sq;
  assign is_bs    = s_tdata == qat_pkg::CH_BACKSLASH;
  assign is_blank = (s_tdata == qat_pkg::CH_SPACE) || (s_tdata == qat_pkg::CH_TAB);
  assign quote_match = (open_quote == qat_pkg::Q_DOUBLE && is_dq) ||
                       (open_quote == qat_pkg::Q_SINGLE && is_sq);

  always_comb begin
    open_quote_next     = open_quote;
    inside_arg_next     = inside_arg;
    escape_pending_next = escape_pending;
    count_of_args_next  = count_of_args;
    char_position_next  = char_position;
    last_end_next       = last_end;
    overflowed_next     = overflowed;
    take  = 1'b0;
    app   = 1'b0;
    newa  = 1'b0;
    ended = 1'b0;
    start = '0;

    if (s_tlast) begin
      open_quote_next     = qat_pkg::Q_NONE;
      inside_arg_next     = 1'b0;
      escape_pending_next = 1'b0;
      count_of_args_next  = '0;
      char_position_next  = '0;
      last_end_next       = '0;
      overflowed_next     = 1'b0;
    end else if (char_position >= qat_pkg::POS_W'(qat_pkg::MAX_LEN)) begin
      // The byte is dropped; only the overflow flag moves.
      overflowed_next = 1'b1;
    end else begin
      if (!inside_arg) begin
        if (!is_blank) begin
          if (is_quote) begin
            open_quote_next = is_dq ? qat_pkg::Q_DOUBLE : qat_pkg::Q_SINGLE;
            start = char_position + 1'b1;
          end else if (is_bs) begin
            escape_pending_next = 1'b1;
            start = char_position + 1'b1;
          end else begin
            take  = 1'b1;
            start = char_position;
          end
          inside_arg_next = 1'b1;
          if (count_of_args >= qat_pkg::CNT_W'(qat_pkg::MAX_ARGS)) begin
            overflowed_next = 1'b1;
          end else if (!overflowed) begin
            count_of_args_next = count_of_args + 1'b1;
            newa = 1'b1;
            last_end_next = start;
          end
          // An argument that is not counted reports no start.
          if (!newa) begin
            start = '0;
          end
        end
      end else if (escape_pending) begin
        take = 1'b1;
        escape_pending_next = 1'b0;
      end else if (is_bs) begin
        escape_pending_next = 1'b1;
      end else if (is_quote) begin
        if (open_quote == qat_pkg::Q_NONE) begin
          open_quote_next = is_dq ? qat_pkg::Q_DOUBLE : qat_pkg::Q_SINGLE;
        end else if (quote_match) begin
          open_quote_next = qat_pkg::Q_NONE;
        end else begin
          take = 1'b1;
        end
      end else if (!is_blank) begin
        take = 1'b1;
      end else if (open_quote == qat_pkg::Q_NONE) begin
        inside_arg_next = 1'b0;
        ended = 1'b1;
      end else begin
        take = 1'b1;
      end

      if (take && !overflowed_next) begin
        app = 1'b1;
        last_end_next = char_position + 1'b1;
      end
      char_position_next = char_position + 1'b1;
    end
  end

  always_comb begin
    res_data = '0;
    if (s_tlast) begin
      if (open_quote != qat_pkg::Q_NONE) begin
        status = qat_pkg::STAT_UNTERMINATED;
      end else if (overflowed) begin
        status = qat_pkg::STAT_OVERFLOW;
      end else begin
        status = qat_pkg::STAT_OK;
      end
      res_data[qat_pkg::STATUS_LSB +: qat_pkg::STATUS_W] = status;
      res_data[qat_pkg::ARG_COUNT_LSB +: qat_pkg::ACNT_W] =
        qat_pkg::ACNT_W'(count_of_args);
    end else begin
      status = overflowed_next ? qat_pkg::STAT_OVERFLOW : qat_pkg::STAT_OK;
      res_data[qat_pkg::APPEND_LSB]                      = app;
      res_data[qat_pkg::OUT_CHAR_LSB +: qat_pkg::CHAR_W] = s_tdata;
      res_data[qat_pkg::NEW_ARG_LSB]                     = newa;
      if (count_of_args_next != '0) begin
        res_data[qat_pkg::ARG_NUM_LSB +: qat_pkg::IDX_W] =
          qat_pkg::IDX_W'(count_of_args_next - 1'b1);
        res_data[qat_pkg::END_POS_LSB +: qat_pkg::SPOS_W] =
          qat_pkg::SPOS_W'(last_end_next);
      end
      res_data[qat_pkg::START_POS_LSB +: qat_pkg::SPOS_W] = qat_pkg::SPOS_W'(start);
      res_data[qat_pkg::ARG_ENDED_LSB]                    = ended;
      res_data[qat_pkg::STATUS_LSB +: qat_pkg::STATUS_W]  = status;
      res_data[qat_pkg::ARG_COUNT_LSB +: qat_pkg::ACNT_W] =
        qat_pkg::ACNT_W'(count_of_args_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_quote     <= qat_pkg::Q_NONE;
      inside_arg     <= 1'b0;
      escape_pending <= 1'b0;
      count_of_args  <= '0;
      char_position  <= '0;
      last_end       <= '0;
      overflowed     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        open_quote     <= open_quote_next;
        inside_arg     <= inside_arg_next;
        escape_pending <= escape_pending_next;
        count_of_args  <= count_of_args_next;
        char_position  <= char_position_next;
        last_end       <= last_end_next;
        overflowed     <= overflowed_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= res_data;
      m_tlast <= s_tlast;
    end
  end

endmodule

`default_nettype wire

// ===== design/qat_checker.sv =====
// Port-level checker for the quoted argument tokenizer, bound to the top level.
// Depends on qat_pkg for the result field layout.
`default_nettype none

module qat_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_tvalid,
  input wire                          s_tready,
  input wire [7:0]                    s_tdata,
  input wire                          s_tlast,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire [qat_pkg::RES_W-1:0]     m_tdata,
  input wire                          m_tlast
);

  logic [qat_pkg::STATUS_W-1:0] res_status;
  logic [qat_pkg::ACNT_W-1:0]   res_count;
  logic                         res_new_arg;
  logic                         in_used;

  assign res_status  = m_tdata[qat_pkg::STATUS_LSB +: qat_pkg::STATUS_W];
  assign res_count   = m_tdata[qat_pkg::ARG_COUNT_LSB +: qat_pkg::ACNT_W];
  assign res_new_arg = m_tdata[qat_pkg::NEW_ARG_LSB];
  assign in_used     = s_tvalid && s_tready && (s_tdata != 8'h00 || s_tlast || !s_tlast);

  // A stalled result must hold.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // Every accepted transaction produces a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_used |=> m_tvalid)
    else $error("accepted transaction produced no result");

  // An end-of-string result carries only status and count.
  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[qat_pkg::STATUS_LSB-1:0] == '0)
    else $error("end-of-string result has stray fields");

  // A counted new argument means no overflow so far and at least one argument.
  a_new_arg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast && res_new_arg |->
      res_status == qat_pkg::STAT_OK && res_count != '0)
    else $error("new argument reported with overflow or zero count");

  // The status code never takes the unused value.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res_status != 2'd3)
    else $error("status out of range");

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
